### sv/pprf_pkg.sv
// pprf_pkg: shared types, constants and helper functions of the rectangle fill unit
// depends on nothing; used by every module under sv/ but pprf_fifo
package pprf_pkg;

  // pixel_format register codes (codes 5 to 7 behave as 8 bpp)
  localparam logic [2:0] FmtMono = 3'd0;
  localparam logic [2:0] Fmt8    = 3'd1;
  localparam logic [2:0] Fmt16   = 3'd2;
  localparam logic [2:0] Fmt24   = 3'd3;
  localparam logic [2:0] Fmt32   = 3'd4;

  // register indexes on the configuration port
  localparam logic [1:0] RegBufferBase  = 2'd0;
  localparam logic [1:0] RegRowStride   = 2'd1;
  localparam logic [1:0] RegPixelFormat = 2'd2;

  localparam logic [31:0] AlphaOpaque = 32'hff00_0000;
  localparam logic [7:0]  ByteOnes    = 8'hff;
  localparam int unsigned RowsW       = 13;

  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdAdvance = 1'b1;

  typedef enum logic [2:0] {
    BppMono,
    Bpp1,
    Bpp2,
    Bpp3,
    Bpp4
  } bpp_e;

  typedef struct packed {
    logic        command;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [12:0] rect_w;
    logic [12:0] rect_h;
    logic [31:0] fill_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [7:0]  write_byte;
    logic [7:0]  bit_mask;
    logic        last_write;
  } out_item_t;

  typedef struct packed {
    logic [31:0] buffer_base;
    logic [15:0] row_stride;
    logic [2:0]  pixel_format;
  } cfg_t;

  // classified command as it waits between front and back
  typedef struct packed {
    logic             is_load;
    logic             is_empty;
    logic [31:0]      row_address;
    logic [RowsW-1:0] rows;
    logic [15:0]      first_byte;
    logic [15:0]      end_byte;
    logic [7:0]       left_mask;
    logic [7:0]       right_mask;
    logic [31:0]      held_value;
  } cmd_t;

  function automatic bpp_e bpp_decode(input logic [2:0] fmt);
    bpp_e b;
    case (fmt)
      FmtMono: b = BppMono;
      Fmt16:   b = Bpp2;
      Fmt24:   b = Bpp3;
      Fmt32:   b = Bpp4;
      default: b = Bpp1;
    endcase
    return b;
  endfunction

  // remainder by three: base-4 digit sum, then fold
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

### sv/packed_pixel_rect_fill_unit.sv
// packed_pixel_rect_fill_unit: top level of the rectangle fill unit, config registers and wiring
// depends on pprf_pkg, pprf_fifo, pprf_front, pprf_back
//
// Rectangle fill engine for a packed-pixel framebuffer. A load word (command 0) latches a
// rectangle and a fill value; every advance word (command 1) then yields one masked byte
// write, left to right along a row and row after row, with last_write set on the final byte.
// Row r starts at buffer_base + row_stride * (rect_y + r). Formats are 1, 8, 16, 24 and
// 32 bpp; in 32 bpp the top byte is forced to 0xff, in 1 bpp the leftmost pixel is the msb
// and the edge bytes carry partial masks. Loads and advances while idle give no write.
// Rate: one input word per clock is accepted and one write per clock leaves, sustained while
// the result side keeps popping; the back end does one address add and compare per write.
// A word passes a front register stage, which does the stride multiply and row geometry,
// then the row base add on entry to a CMD_DEPTH-deep command queue; the back end writes into
// a two-entry result queue, so either side may stall without holding up the other.
// Registers sit at byte offsets 0 (buffer_base), 4 (row_stride) and 8 (pixel_format);
// pixel_format codes 5 to 7 act as 8 bpp. row_stride and pixel_format are sampled again
// at every advance.
module packed_pixel_rect_fill_unit #(
  parameter int MAX_EXTENT = 4096,
  parameter int CMD_DEPTH  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item side
  input  logic                push,
  output logic                full,
  input  pprf_pkg::in_item_t  in_item_i,
  // result side
  output logic                empty,
  input  logic                pop,
  output pprf_pkg::out_item_t out_item_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration registers
  logic [31:0] base_q, base_d;
  logic [15:0] stride_q, stride_d;
  logic [2:0]  fmt_q, fmt_d;
  logic [1:0]  reg_index;
  logic        cfg_write;
  pprf_pkg::cfg_t cfg;

  // front to queue
  logic           q_push, q_full, q_empty, q_pop;
  pprf_pkg::cmd_t q_cmd_in, q_cmd_out;

  // back to result queue
  logic                res_push, res_full;
  pprf_pkg::out_item_t res_item;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    base_d   = base_q;
    stride_d = stride_q;
    fmt_d    = fmt_q;
    if (cfg_write) begin
      case (reg_index)
        pprf_pkg::RegBufferBase:  base_d   = pwdata;
        pprf_pkg::RegRowStride:   stride_d = pwdata[15:0];
        pprf_pkg::RegPixelFormat: fmt_d    = pwdata[2:0];
        default: ; // unmapped offset, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      pprf_pkg::RegBufferBase:  prdata = base_q;
      pprf_pkg::RegRowStride:   prdata = 32'(stride_q);
      pprf_pkg::RegPixelFormat: prdata = 32'(fmt_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      stride_q <= 16'd1;
      fmt_q    <= pprf_pkg::Fmt8;
    end else begin
      base_q   <= base_d;
      stride_q <= stride_d;
      fmt_q    <= fmt_d;
    end
  end

  assign cfg.buffer_base  = base_q;
  assign cfg.row_stride   = stride_q;
  assign cfg.pixel_format = fmt_q;

  // front: accept and classify
  pprf_front #(
    .MAX_EXTENT(MAX_EXTENT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .cfg_i   (cfg),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_cmd_o (q_cmd_in)
  );

  // command queue decoupling front and back
  pprf_fifo #(
    .WIDTH($bits(pprf_pkg::cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_cmd_out),
    .empty_o(q_empty)
  );

  // back: walk the rectangle one byte per advance
  pprf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_i      (q_cmd_out),
    .cmd_pop_o  (q_pop),
    .cfg_i      (cfg),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_item)
  );

  // result queue, head drives the output ports
  pprf_fifo #(
    .WIDTH($bits(pprf_pkg::out_item_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_item),
    .full_o (res_full),
    .pop_i  (pop && !empty),
    .data_o (out_item_o),
    .empty_o(empty)
  );

endmodule

### sv/pprf_fifo.sv
// pprf_fifo: small register-based first-in first-out queue of packed words
// depends on nothing; used for the command queue and the result queue
module pprf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fifo count above depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("fifo empty after a lone push");

endmodule

### sv/pprf_front.sv
// pprf_front: accepts items, works out rectangle geometry for loads, feeds the command queue
// depends on pprf_pkg
module pprf_front #(
  parameter int MAX_EXTENT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pprf_pkg::in_item_t item_i,
  output logic               full_o,
  input  pprf_pkg::cfg_t     cfg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output pprf_pkg::cmd_t     q_cmd_o
);

  typedef struct packed {
    logic                       is_load;
    logic                       is_empty;
    logic [27:0]                y_offset;
    logic [pprf_pkg::RowsW-1:0] rows;
    logic [15:0]                first_byte;
    logic [15:0]                end_byte;
    logic [7:0]                 left_mask;
    logic [7:0]                 right_mask;
    logic [31:0]                held_value;
  } pre_cmd_t;

  pre_cmd_t      pre_d, pre_q;
  logic          valid_d, valid_q;
  logic          accept;
  logic [12:0]   w_c, h_c;
  logic [13:0]   last_pix, x_end;
  logic [11:0]   x;
  pprf_pkg::bpp_e bpp;

  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_full_i;

  assign x   = item_i.rect_x;
  assign bpp = pprf_pkg::bpp_decode(cfg_i.pixel_format);

  // extents saturate at the configured maximum
  assign w_c = (32'(item_i.rect_w) > 32'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : item_i.rect_w;
  assign h_c = (32'(item_i.rect_h) > 32'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : item_i.rect_h;
  assign x_end    = 14'(x) + 14'(w_c);
  assign last_pix = x_end - 14'd1;

  always_comb begin
    pre_d            = '0;
    pre_d.is_load    = (item_i.command == pprf_pkg::CmdLoad);
    pre_d.is_empty   = (w_c == '0) || (h_c == '0);
    pre_d.y_offset   = 28'(cfg_i.row_stride) * 28'(item_i.rect_y);
    pre_d.rows       = h_c;
    pre_d.left_mask  = pprf_pkg::ByteOnes;
    pre_d.right_mask = pprf_pkg::ByteOnes;
    pre_d.held_value = item_i.fill_value;
    case (bpp)
      pprf_pkg::BppMono: begin
        pre_d.held_value = item_i.fill_value[0] ? 32'(pprf_pkg::ByteOnes) : 32'd0;
        pre_d.first_byte = 16'(x[11:3]);
        pre_d.end_byte   = 16'(last_pix[13:3]);
        pre_d.left_mask  = pprf_pkg::ByteOnes >> x[2:0];
        pre_d.right_mask = pprf_pkg::ByteOnes << (3'd7 - last_pix[2:0]);
      end
      pprf_pkg::Bpp2: begin
        pre_d.first_byte = 16'({x, 1'b0});
        pre_d.end_byte   = 16'({x_end, 1'b0}) - 16'd1;
      end
      pprf_pkg::Bpp3: begin
        pre_d.first_byte = 16'(x) + 16'({x, 1'b0});
        pre_d.end_byte   = 16'(x_end) + 16'({x_end, 1'b0}) - 16'd1;
      end
      pprf_pkg::Bpp4: begin
        pre_d.held_value = item_i.fill_value | pprf_pkg::AlphaOpaque;
        pre_d.first_byte = 16'({x, 2'b00});
        pre_d.end_byte   = {x_end, 2'b00} - 16'd1;
      end
      default: begin
        pre_d.first_byte = 16'(x);
        pre_d.end_byte   = 16'(x_end) - 16'd1;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pre_q <= pre_d;
    end
  end

  // row start address finished on the way into the queue
  always_comb begin
    q_cmd_o             = '0;
    q_cmd_o.is_load     = pre_q.is_load;
    q_cmd_o.is_empty    = pre_q.is_empty;
    q_cmd_o.row_address = cfg_i.buffer_base + 32'(pre_q.y_offset);
    q_cmd_o.rows        = pre_q.rows;
    q_cmd_o.first_byte  = pre_q.first_byte;
    q_cmd_o.end_byte    = pre_q.end_byte;
    q_cmd_o.left_mask   = pre_q.left_mask;
    q_cmd_o.right_mask  = pre_q.right_mask;
    q_cmd_o.held_value  = pre_q.held_value;
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && q_full_i) |=> valid_q)
    else $error("front stage dropped a stalled command");

endmodule

### sv/pprf_back.sv
// pprf_back: holds the fill state and turns each advance during a fill into one masked byte write
// depends on pprf_pkg
module pprf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  pprf_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  pprf_pkg::cfg_t      cfg_i,
  input  logic                res_full_i,
  output logic                res_push_o,
  output pprf_pkg::out_item_t res_o
);

  logic                       busy_d, busy_q;
  logic [31:0]                row_addr_d, row_addr_q;
  logic [pprf_pkg::RowsW-1:0] rows_d, rows_q;
  logic [15:0]                off_d, off_q;
  logic [15:0]                first_d, first_q;
  logic [15:0]                end_d, end_q;
  logic [7:0]                 lmask_d, lmask_q;
  logic [7:0]                 rmask_d, rmask_q;
  logic [31:0]                held_d, held_q;

  logic           issue, at_end, last;
  logic [1:0]     lane;
  pprf_pkg::bpp_e bpp;

  assign issue      = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = issue;
  assign res_push_o = issue && !cmd_i.is_load && busy_q;

  assign bpp    = pprf_pkg::bpp_decode(cfg_i.pixel_format);
  assign at_end = (off_q == end_q);
  assign last   = at_end && (rows_q <= pprf_pkg::RowsW'(1));

  always_comb begin
    case (bpp)
      pprf_pkg::Bpp2: lane = {1'b0, off_q[0]};
      pprf_pkg::Bpp3: lane = pprf_pkg::mod3_16(off_q);
      pprf_pkg::Bpp4: lane = off_q[1:0];
      default:        lane = 2'd0;
    endcase
  end

  always_comb begin
    res_o               = '0;
    res_o.write_address = row_addr_q + 32'(off_q);
    res_o.bit_mask      = pprf_pkg::ByteOnes;
    if (off_q == first_q) begin
      res_o.bit_mask = res_o.bit_mask & lmask_q;
    end
    if (at_end) begin
      res_o.bit_mask = res_o.bit_mask & rmask_q;
    end
    if (bpp == pprf_pkg::BppMono) begin
      res_o.write_byte = held_q[0] ? pprf_pkg::ByteOnes : 8'h00;
    end else begin
      res_o.write_byte = 8'(held_q >> {lane, 3'b000});
    end
    res_o.last_write = last;
  end

  always_comb begin
    busy_d     = busy_q;
    row_addr_d = row_addr_q;
    rows_d     = rows_q;
    off_d      = off_q;
    first_d    = first_q;
    end_d      = end_q;
    lmask_d    = lmask_q;
    rmask_d    = rmask_q;
    held_d     = held_q;
    if (issue && cmd_i.is_load) begin
      // a load drops any fill under way
      busy_d     = !cmd_i.is_empty;
      row_addr_d = cmd_i.row_address;
      rows_d     = cmd_i.rows;
      off_d      = cmd_i.first_byte;
      first_d    = cmd_i.first_byte;
      end_d      = cmd_i.end_byte;
      lmask_d    = cmd_i.left_mask;
      rmask_d    = cmd_i.right_mask;
      held_d     = cmd_i.held_value;
    end else if (res_push_o) begin
      if (at_end) begin
        off_d      = first_q;
        row_addr_d = row_addr_q + 32'(cfg_i.row_stride);
        rows_d     = rows_q - 1'b1;
        if (last) begin
          busy_d = 1'b0;
        end
      end else begin
        off_d = off_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      row_addr_q <= '0;
      rows_q     <= '0;
      off_q      <= '0;
      first_q    <= '0;
      end_q      <= '0;
      lmask_q    <= '0;
      rmask_q    <= '0;
      held_q     <= '0;
    end else begin
      busy_q     <= busy_d;
      row_addr_q <= row_addr_d;
      rows_q     <= rows_d;
      off_q      <= off_d;
      first_q    <= first_d;
      end_q      <= end_d;
      lmask_q    <= lmask_d;
      rmask_q    <= rmask_d;
      held_q     <= held_d;
    end
  end

  a_offset_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (off_q >= first_q) && (off_q <= end_q))
    else $error("byte offset left the row range");

  a_last_ends_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && last) |=> !busy_q)
    else $error("fill still busy after its last write");

endmodule

### dv/pprf_fill_checker.sv
// pprf_fill_checker: watches the word, result and register channels of the fill unit,
// predicts every byte write and compares it field by field
// depends on pprf_pkg
module pprf_fill_checker #(
  parameter int unsigned MaxExtent = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  pprf_pkg::in_item_t  in_item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  pprf_pkg::out_item_t out_item_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [3:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output int unsigned         failures_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies, reset values
  logic [31:0] base_q   = '0;
  logic [15:0] stride_q = 16'd1;
  logic [2:0]  fmt_q    = pprf_pkg::Fmt8;

  // fill engine copy
  logic                       filling    = 1'b0;
  logic [31:0]                row_base   = '0;
  logic [pprf_pkg::RowsW-1:0] rows_left  = '0;
  logic [15:0]                byte_pos   = '0;
  logic [15:0]                first_byte = '0;
  logic [15:0]                last_byte  = '0;
  logic [7:0]                 left_mask  = '0;
  logic [7:0]                 right_mask = '0;
  logic [31:0]                fill_data  = '0;

  pprf_pkg::out_item_t writes_due[$];
  pprf_pkg::out_item_t due;

  initial begin
    failures_o = 0;
    pending_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures_o++;
  endtask

  // bytes per pixel, zero for 1 bpp
  function automatic int unsigned pixel_bytes(input logic [2:0] fmt);
    case (fmt)
      pprf_pkg::FmtMono: return 0;
      pprf_pkg::Fmt16:   return 2;
      pprf_pkg::Fmt24:   return 3;
      pprf_pkg::Fmt32:   return 4;
      default:           return 1;
    endcase
  endfunction

  task automatic start_fill(input pprf_pkg::in_item_t w);
    int unsigned width, height, nbytes;
    logic [13:0] span_end;
    width  = w.rect_w;
    height = w.rect_h;
    if (width > MaxExtent) width = MaxExtent;
    if (height > MaxExtent) height = MaxExtent;
    nbytes    = pixel_bytes(fmt_q);
    fill_data = w.fill_value;
    filling   = 1'b0;
    if (width == 0 || height == 0) return;
    span_end = 14'(w.rect_x + width - 1);
    if (nbytes == 0) begin
      fill_data  = w.fill_value[0] ? 32'h0000_00ff : 32'h0;
      first_byte = 16'(w.rect_x >> 3);
      last_byte  = 16'(span_end >> 3);
      left_mask  = pprf_pkg::ByteOnes >> w.rect_x[2:0];
      right_mask = pprf_pkg::ByteOnes << (3'd7 - span_end[2:0]);
    end else begin
      if (nbytes == 4) fill_data = fill_data | pprf_pkg::AlphaOpaque;
      first_byte = 16'(w.rect_x * nbytes);
      last_byte  = 16'((w.rect_x + width) * nbytes - 1);
      left_mask  = pprf_pkg::ByteOnes;
      right_mask = pprf_pkg::ByteOnes;
    end
    byte_pos  = first_byte;
    row_base  = base_q + 32'(stride_q) * 32'(w.rect_y);
    rows_left = pprf_pkg::RowsW'(height);
    filling   = 1'b1;
  endtask

  // stride and format are taken fresh on every advance
  function automatic pprf_pkg::out_item_t next_fill_write();
    pprf_pkg::out_item_t e;
    int unsigned         nbytes;
    logic                at_end;
    nbytes = pixel_bytes(fmt_q);
    at_end = (byte_pos == last_byte);
    e.bit_mask = pprf_pkg::ByteOnes;
    if (byte_pos == first_byte) e.bit_mask = e.bit_mask & left_mask;
    if (at_end) e.bit_mask = e.bit_mask & right_mask;
    if (nbytes == 0) e.write_byte = fill_data[0] ? pprf_pkg::ByteOnes : 8'h00;
    else e.write_byte = 8'(fill_data >> (8 * (byte_pos % nbytes)));
    e.write_address = row_base + 32'(byte_pos);
    e.last_write    = at_end && (rows_left <= 1);
    if (at_end) begin
      byte_pos  = first_byte;
      row_base  = row_base + 32'(stride_q);
      rows_left = rows_left - 1'b1;
      if (e.last_write) filling = 1'b0;
    end else begin
      byte_pos = byte_pos + 16'd1;
    end
    return e;
  endfunction

  task automatic check_write();
    if (writes_due.size() == 0) begin
      report_mismatch($sformatf("write to %h with nothing due", out_item_i.write_address));
      return;
    end
    due = writes_due.pop_front();
    if (out_item_i.write_address !== due.write_address)
      report_mismatch($sformatf("write_address %h, expected %h",
                                out_item_i.write_address, due.write_address));
    if (out_item_i.write_byte !== due.write_byte)
      report_mismatch($sformatf("write_byte %h, expected %h at %h",
                                out_item_i.write_byte, due.write_byte, due.write_address));
    if (out_item_i.bit_mask !== due.bit_mask)
      report_mismatch($sformatf("bit_mask %h, expected %h at %h",
                                out_item_i.bit_mask, due.bit_mask, due.write_address));
    if (out_item_i.last_write !== due.last_write)
      report_mismatch($sformatf("last_write %b, expected %b at %h",
                                out_item_i.last_write, due.last_write, due.write_address));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_i) check_write();
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          pprf_pkg::RegBufferBase:  base_q   = pwdata_i;
          pprf_pkg::RegRowStride:   stride_q = pwdata_i[15:0];
          pprf_pkg::RegPixelFormat: fmt_q    = pwdata_i[2:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        if (in_item_i.command == pprf_pkg::CmdLoad) start_fill(in_item_i);
        else if (filling) writes_due.push_back(next_fill_write());
      end
      pending_o <= writes_due.size();
    end
  end

endmodule

### dv/packed_pixel_rect_fill_unit_test.sv
// packed_pixel_rect_fill_unit_test: stimulus and verdict for the rectangle fill unit
// depends on pprf_pkg, the fill unit rtl and dv/pprf_fill_checker.sv
module packed_pixel_rect_fill_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxExtent   = 4096;
  // clocks allowed after the last due write for words that leave no write
  localparam int unsigned SettleClks  = 12;
  localparam int unsigned PhaseWords  = 145;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned AdvanceCap  = 400;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                push     = 1'b0;
  logic                full;
  pprf_pkg::in_item_t  in_item  = '0;
  logic                empty;
  logic                pop      = 1'b0;
  pprf_pkg::out_item_t out_item;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [3:0]          paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned mismatches;
  int unsigned writes_pending;

  // set for the tail of the run: no more idling on either side
  bit calm = 1'b0;
  // format as last written, used to plan how many advances a rectangle needs
  logic [2:0] fmt_now = pprf_pkg::Fmt8;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  packed_pixel_rect_fill_unit #(
    .MAX_EXTENT(MaxExtent)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pprf_fill_checker #(
    .MaxExtent(MaxExtent)
  ) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (full),
    .in_item_i (in_item),
    .empty_i   (empty),
    .pop_i     (pop),
    .out_item_i(out_item),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .pready_i  (pready),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .failures_o(mismatches),
    .pending_o (writes_pending)
  );

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------

  // every field random, command too
  function automatic pprf_pkg::in_item_t random_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(pprf_pkg::in_item_t)-1:0];
  endfunction

  // advance words carry random junk in the unused fields
  function automatic pprf_pkg::in_item_t advance_word();
    pprf_pkg::in_item_t w;
    w = random_word();
    w.command = pprf_pkg::CmdAdvance;
    return w;
  endfunction

  function automatic pprf_pkg::in_item_t load_word(input logic [11:0] x,
                                                   input logic [11:0] y,
                                                   input logic [12:0] w,
                                                   input logic [12:0] h,
                                                   input logic [31:0] fill);
    pprf_pkg::in_item_t v;
    v.command    = pprf_pkg::CmdLoad;
    v.rect_x     = x;
    v.rect_y     = y;
    v.rect_w     = w;
    v.rect_h     = h;
    v.fill_value = fill;
    return v;
  endfunction

  // byte writes a rectangle takes in the current format
  function automatic int unsigned rect_writes(input logic [11:0] x, input logic [12:0] w,
                                              input logic [12:0] h);
    int unsigned cw, ch, per_row;
    cw = w;
    ch = h;
    if (cw > MaxExtent) cw = MaxExtent;
    if (ch > MaxExtent) ch = MaxExtent;
    if (cw == 0 || ch == 0) return 0;
    case (fmt_now)
      pprf_pkg::FmtMono: per_row = ((x + cw - 1) >> 3) - (x >> 3) + 1;
      pprf_pkg::Fmt16:   per_row = 2 * cw;
      pprf_pkg::Fmt24:   per_row = 3 * cw;
      pprf_pkg::Fmt32:   per_row = 4 * cw;
      default:           per_row = cw;
    endcase
    return per_row * ch;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // push stays high from word to word; a gap lowers it for a random burst
  task automatic send_word(input pprf_pkg::in_item_t w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // setup, then access, then idle with psel low, so back-to-back writes
  // never drive psel twice in one step
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == pprf_pkg::RegPixelFormat) fmt_now = value[2:0];
  endtask

  // stop sending, wait for every due write, then let loads and idle
  // advances still in the pipe drain out
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (writes_pending != 0) @(posedge clk_i);
    repeat (SettleClks) @(posedge clk_i);
  endtask

  // new register values between phases and mid-fill, extremes about one time in two
  task automatic reconfigure(input bit all_regs, input logic [2:0] fmt);
    logic [31:0] base;
    logic [15:0] stride;
    settle();
    case ($urandom_range(0, 5))
      0:       begin base = 32'h0;         stride = 16'hffff; end
      1:       begin base = 32'hffff_ffff; stride = 16'd1;    end
      2:       begin base = 32'hffff_fff0; stride = 16'h0;    end
      default: begin base = $urandom;      stride = 16'($urandom_range(1, 65535)); end
    endcase
    if (all_regs) write_reg(pprf_pkg::RegBufferBase, base);
    write_reg(pprf_pkg::RegRowStride, {16'h0, stride});
    write_reg(pprf_pkg::RegPixelFormat, {29'h0, fmt});
  endtask

  // result side: pop held high in stretches, dropped in random bursts
  initial begin : result_side
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random traffic: mostly whole rectangles with random geometry, some cut
  // short, some overrun into idle advances, some reconfigured mid-fill, and
  // a share of raw noise words
  // ---------------------------------------------------------------------------
  task automatic random_phase(input int unsigned words);
    int unsigned done, kind, planned;
    logic [11:0] x, y;
    logic [12:0] w, h;
    done = 0;
    while (done < words) begin
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        send_word(random_word());
        done++;
      end else begin
        x = 12'($urandom);
        y = 12'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          // one long row, reaches far right edges in 1 bpp
          w = 13'($urandom_range(1, 300));
          h = 13'd1;
        end else begin
          w = 13'($urandom_range(1, 10));
          h = 13'($urandom_range(1, 4));
        end
        planned = rect_writes(x, w, h);
        if (planned > AdvanceCap) planned = AdvanceCap;
        // keep the phase close to its word budget
        if (planned + 1 > words - done) planned = words - done - 1;
        if (kind == 1) planned = $urandom_range(0, planned);
        else if (kind == 2) planned = planned + $urandom_range(1, 3);
        send_word(load_word(x, y, w, h, $urandom));
        for (int i = 0; i < planned; i++) begin
          // stride and format change while the rectangle is half done
          if (kind == 3 && i == planned / 2) reconfigure(1'b0, 3'($urandom_range(0, 7)));
          send_word(advance_word());
        end
        done = done + 1 + planned;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: 8 bpp, stride 1, base 0
    send_word(advance_word());                                     // advance while idle
    send_word(load_word(12'd0, 12'd0, 13'd3, 13'd2, 32'h1234_5678));
    repeat (6) send_word(advance_word());
    send_word(load_word(12'd7, 12'd9, 13'd0, 13'd5, $urandom));     // zero width
    send_word(advance_word());
    send_word(load_word(12'd7, 12'd9, 13'd4, 13'd0, $urandom));     // zero height
    send_word(advance_word());
    // oversize extents saturate; the fill is then dropped by the next load
    send_word(load_word(12'hfff, 12'hfff, 13'h1fff, 13'h1fff, 32'hffff_ffff));
    repeat (3) send_word(advance_word());
    send_word(load_word(12'd1, 12'd2, 13'd2, 13'd1, 32'h0));
    repeat (2) send_word(advance_word());

    // 1 bpp, wrapping addresses, widest stride
    reconfigure(1'b0, pprf_pkg::FmtMono);
    write_reg(pprf_pkg::RegBufferBase, 32'hffff_ff00);
    write_reg(pprf_pkg::RegRowStride, 32'h0000_ffff);
    // narrow rectangle inside one byte: both edge masks on every write
    send_word(load_word(12'd3, 12'd1, 13'd2, 13'd3, 32'h1));
    repeat (3) send_word(advance_word());
    // partial masks at both ends of a three-byte row
    send_word(load_word(12'd5, 12'd0, 13'd12, 13'd1, 32'hffff_fffe));
    repeat (2) send_word(advance_word());

    // every format code in turn, including the ones that fall back to 8 bpp
    for (int p = 0; p < RandPhases; p++) begin
      reconfigure(1'b1, (p < 8) ? 3'(p) : 3'($urandom_range(0, 7)));
      if (p == RandPhases - 1) calm = 1'b1;
      random_phase(PhaseWords);
    end

    settle();
    if (mismatches == 0 && writes_pending == 0) begin
      $display("packed_pixel_rect_fill_unit_test passed");
    end else begin
      $display("packed_pixel_rect_fill_unit_test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("packed_pixel_rect_fill_unit_test failed");
    $finish;
  end

endmodule
